[sv/mbat_pkg.sv]
// ----------------------------------------------------------------------------
// mbat_pkg
// Shared types, codes and helpers for the cartridge bank access translator.
// ----------------------------------------------------------------------------
package mbat_pkg;

    localparam int unsigned MAX_RESULTS = 4;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_WRITE  = 2'd0;
    localparam t_kind KIND_RUN    = 2'd1;
    localparam t_kind KIND_REJECT = 2'd2;

    localparam logic [15:0] ADDR_RAM_ENABLE   = 16'h0000;
    localparam logic [15:0] ADDR_ROM_BANK_SEL = 16'h2000;
    localparam logic [15:0] ADDR_MBC2_ROM_SEL = 16'h2100;
    localparam logic [15:0] ADDR_MBC5_ROM_HI  = 16'h3000;
    localparam logic [15:0] ADDR_RAM_BANK_SEL = 16'h4000;

    localparam logic [7:0] RAM_ENABLE_KEY  = 8'h0A;
    localparam logic [7:0] RAM_DISABLE_KEY = 8'h00;

    localparam logic [1:0] ROM_SWITCH_TOP = 2'b01;   // 0x4000 window
    localparam logic [2:0] RAM_WINDOW_TOP = 3'b101;  // 0xA000 window

    localparam logic [23:0] ROM_PLAIN_END = 24'h00_8000;
    localparam logic [23:0] ROM_FIXED_END = 24'h00_4000;
    localparam logic [23:0] RAM_BANK_END  = 24'h00_2000;
    localparam logic [23:0] MBC2_RAM_END  = 24'h00_0200;
    localparam logic [15:0] ROM_BANK_SIZE = 16'h4000;
    localparam logic [15:0] RAM_BANK_SIZE = 16'h2000;

    localparam logic [15:0] RAM_WINDOW_BASE = 16'hA000;

    typedef enum logic [2:0] {
        MAP_NONE = 3'd0,
        MAP_MBC1 = 3'd1,
        MAP_MBC2 = 3'd2,
        MAP_MBC3 = 3'd3,
        MAP_MBC5 = 3'd5,
        MAP_MBC7 = 3'd7
    } t_mapper;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] bus_address;
        logic [7:0]  write_value;
        logic [14:0] run_length;
        logic        fill_high_nibble;
        logic        last;
    } t_result;

    typedef struct packed {
        t_result [MAX_RESULTS-1:0] res;
        logic [1:0]                last_idx;
    } t_plan;

    function automatic t_mapper f_mapper(logic [7:0] cart);
        t_mapper m;
        m = MAP_NONE;
        case (cart) inside
            [8'h01:8'h03]: m = MAP_MBC1;
            [8'h05:8'h06]: m = MAP_MBC2;
            [8'h0F:8'h13]: m = MAP_MBC3;
            [8'h19:8'h1E]: m = MAP_MBC5;
            8'h22:         m = MAP_MBC7;
            default:       m = MAP_NONE;
        endcase
        return m;
    endfunction

    function automatic t_result f_write(logic [15:0] a, logic [7:0] v, logic l);
        t_result r;
        r.kind             = KIND_WRITE;
        r.bus_address      = a;
        r.write_value      = v;
        r.run_length       = '0;
        r.fill_high_nibble = 1'b0;
        r.last             = l;
        return r;
    endfunction

    function automatic t_result f_run(logic [15:0] a, logic [14:0] len, logic fill,
                                      logic l);
        t_result r;
        r.kind             = KIND_RUN;
        r.bus_address      = a;
        r.write_value      = '0;
        r.run_length       = len;
        r.fill_high_nibble = fill;
        r.last             = l;
        return r;
    endfunction

    function automatic t_result f_reject();
        t_result r;
        r.kind             = KIND_REJECT;
        r.bus_address      = '0;
        r.write_value      = '0;
        r.run_length       = '0;
        r.fill_high_nibble = 1'b0;
        r.last             = 1'b1;
        return r;
    endfunction

endpackage

[sv/mbat_if.sv]
// ----------------------------------------------------------------------------
// mbat request and result channels
// Valid/ready channels carrying one request beat and one result beat.
// ----------------------------------------------------------------------------
interface mbat_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [22:0] cart_address;
    logic [14:0] byte_count;

    modport source (output valid, output command, output cart_address,
                    output byte_count, input ready);
    modport sink   (input valid, input command, input cart_address,
                    input byte_count, output ready);
endinterface

interface mbat_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] bus_address;
    logic [7:0]  write_value;
    logic [14:0] run_length;
    logic        fill_high_nibble;
    logic        last;

    modport source (output valid, output kind, output bus_address,
                    output write_value, output run_length,
                    output fill_high_nibble, output last, input ready);
    modport sink   (input valid, input kind, input bus_address,
                    input write_value, input run_length,
                    input fill_high_nibble, input last, output ready);
endinterface

[sv/mbat_bank_access_translator_unit.sv]
// ----------------------------------------------------------------------------
// mbc_bank_access_translator_unit
// Turns cartridge ROM/RAM read requests into ordered bus write and read beats.
// ----------------------------------------------------------------------------
// a request beat is classified in the cycle it is taken and its one to four
// result beats go into a two-entry plan queue; the result sequencer then
// sends one result beat per cycle from an output register while the sink is
// ready, and requests are taken every cycle while the queue has room; the
// mapper is decoded from cart_type, written through i_cfg_we / i_cfg_wdata
module mbc_bank_access_translator_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    mbat_req_if.sink   i_req,
    mbat_rsp_if.source o_rsp
);

    logic [7:0]      r_cart_type;
    logic            push;
    logic            push_ready;
    logic            pop;
    logic            empty;
    mbat_pkg::t_plan plan;
    mbat_pkg::t_plan head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cart_type <= 8'h00;
        end else if (i_cfg_we) begin
            r_cart_type <= i_cfg_wdata;
        end
    end

    mbat_front u_front (
        .i_cart_type  (r_cart_type),
        .i_req        (i_req),
        .o_push       (push),
        .o_plan       (plan),
        .i_push_ready (push_ready)
    );

    mbat_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_plan  (plan),
        .o_ready (push_ready),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    mbat_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

`ifndef NO_ASSERTIONS
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid)
        else $error("result beat right after reset");

    a_reject_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.kind == mbat_pkg::KIND_REJECT
        |-> o_rsp.last && o_rsp.run_length == '0)
        else $error("reject beat not final or has a run length");

    a_fill_ram_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.fill_high_nibble
        |-> o_rsp.kind == mbat_pkg::KIND_RUN
            && o_rsp.bus_address[15:13] == mbat_pkg::RAM_WINDOW_TOP)
        else $error("nibble fill outside a ram read run");

    a_write_no_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.kind == mbat_pkg::KIND_WRITE |-> o_rsp.run_length == '0)
        else $error("bus write beat with a run length");
`endif

endmodule

[sv/mbat_front.sv]
// ----------------------------------------------------------------------------
// mbat_front
// Classifies a request beat against the mapper and builds its result plan.
// ----------------------------------------------------------------------------
module mbat_front (
    input  logic [7:0]      i_cart_type,
    mbat_req_if.sink        i_req,
    output logic            o_push,
    output mbat_pkg::t_plan o_plan,
    input  logic            i_push_ready
);

    mbat_pkg::t_mapper m;
    logic [22:0] a;
    logic [14:0] c;
    logic [23:0] lin_end;
    logic [15:0] rom_off_end;
    logic [15:0] ram_off_end;
    logic [8:0]  rom_bank;
    logic [9:0]  ram_bank;
    logic [15:0] rom_run_addr;
    logic [15:0] ram_run_addr;

    assign m            = mbat_pkg::f_mapper(i_cart_type);
    assign a            = i_req.cart_address;
    assign c            = i_req.byte_count;
    assign lin_end      = {1'b0, a} + {9'b0, c};
    assign rom_off_end  = {2'b0, a[13:0]} + {1'b0, c};
    assign ram_off_end  = {3'b0, a[12:0]} + {1'b0, c};
    assign rom_bank     = a[22:14];
    assign ram_bank     = a[22:13];
    assign rom_run_addr = {mbat_pkg::ROM_SWITCH_TOP, a[13:0]};
    assign ram_run_addr = {mbat_pkg::RAM_WINDOW_TOP, a[12:0]};

    assign i_req.ready = i_push_ready;
    assign o_push      = i_req.valid && i_push_ready;

    always_comb begin
        o_plan          = '0;
        o_plan.res[0]   = mbat_pkg::f_reject();
        o_plan.last_idx = 2'd0;
        if (c == '0) begin
            o_plan.res[0] = mbat_pkg::f_reject();
        end else if (!i_req.command) begin
            if (m == mbat_pkg::MAP_NONE) begin
                if (lin_end <= mbat_pkg::ROM_PLAIN_END) begin
                    o_plan.res[0] = mbat_pkg::f_run(a[15:0], c, 1'b0, 1'b1);
                end
            end else if (a < 23'(mbat_pkg::ROM_FIXED_END)) begin
                if (lin_end <= mbat_pkg::ROM_FIXED_END) begin
                    o_plan.res[0] = mbat_pkg::f_run(a[15:0], c, 1'b0, 1'b1);
                end
            end else if (rom_off_end <= mbat_pkg::ROM_BANK_SIZE) begin
                case (m)
                    mbat_pkg::MAP_MBC1: begin
                        if (rom_bank <= 9'h01F) begin
                            o_plan.res[0] = mbat_pkg::f_write(
                                mbat_pkg::ADDR_ROM_BANK_SEL, rom_bank[7:0], 1'b0);
                            o_plan.res[1] = mbat_pkg::f_run(rom_run_addr, c, 1'b0, 1'b1);
                            o_plan.last_idx = 2'd1;
                        end
                    end
                    mbat_pkg::MAP_MBC2: begin
                        if (rom_bank <= 9'h00F) begin
                            o_plan.res[0] = mbat_pkg::f_write(
                                mbat_pkg::ADDR_MBC2_ROM_SEL, rom_bank[7:0], 1'b0);
                            o_plan.res[1] = mbat_pkg::f_run(rom_run_addr, c, 1'b0, 1'b1);
                            o_plan.last_idx = 2'd1;
                        end
                    end
                    mbat_pkg::MAP_MBC5: begin
                        o_plan.res[0] = mbat_pkg::f_write(
                            mbat_pkg::ADDR_ROM_BANK_SEL, rom_bank[7:0], 1'b0);
                        o_plan.res[1] = mbat_pkg::f_write(
                            mbat_pkg::ADDR_MBC5_ROM_HI, {7'b0, rom_bank[8]}, 1'b0);
                        o_plan.res[2] = mbat_pkg::f_run(rom_run_addr, c, 1'b0, 1'b1);
                        o_plan.last_idx = 2'd2;
                    end
                    default: begin
                        if (!rom_bank[8]) begin
                            o_plan.res[0] = mbat_pkg::f_write(
                                mbat_pkg::ADDR_ROM_BANK_SEL, rom_bank[7:0], 1'b0);
                            o_plan.res[1] = mbat_pkg::f_run(rom_run_addr, c, 1'b0, 1'b1);
                            o_plan.last_idx = 2'd1;
                        end
                    end
                endcase
            end
        end else begin
            case (m)
                mbat_pkg::MAP_NONE: begin
                    if (lin_end <= mbat_pkg::RAM_BANK_END) begin
                        o_plan.res[0] = mbat_pkg::f_run(ram_run_addr, c, 1'b0, 1'b1);
                    end
                end
                mbat_pkg::MAP_MBC2: begin
                    if (lin_end <= mbat_pkg::MBC2_RAM_END) begin
                        o_plan.res[0] = mbat_pkg::f_write(mbat_pkg::ADDR_RAM_ENABLE,
                                                          mbat_pkg::RAM_ENABLE_KEY, 1'b0);
                        o_plan.res[1] = mbat_pkg::f_run(ram_run_addr, c, 1'b1, 1'b0);
                        o_plan.res[2] = mbat_pkg::f_write(mbat_pkg::ADDR_RAM_ENABLE,
                                                          mbat_pkg::RAM_DISABLE_KEY, 1'b1);
                        o_plan.last_idx = 2'd2;
                    end
                end
                mbat_pkg::MAP_MBC1: begin
                    if (lin_end <= mbat_pkg::RAM_BANK_END) begin
                        o_plan.res[0] = mbat_pkg::f_write(mbat_pkg::ADDR_RAM_ENABLE,
                                                          mbat_pkg::RAM_ENABLE_KEY, 1'b0);
                        o_plan.res[1] = mbat_pkg::f_run(ram_run_addr, c, 1'b0, 1'b0);
                        o_plan.res[2] = mbat_pkg::f_write(mbat_pkg::ADDR_RAM_ENABLE,
                                                          mbat_pkg::RAM_DISABLE_KEY, 1'b1);
                        o_plan.last_idx = 2'd2;
                    end
                end
                mbat_pkg::MAP_MBC3, mbat_pkg::MAP_MBC5: begin
                    if ((ram_bank <= ((m == mbat_pkg::MAP_MBC3) ? 10'd7 : 10'd15))
                        && (ram_off_end <= mbat_pkg::RAM_BANK_SIZE)) begin
                        o_plan.res[0] = mbat_pkg::f_write(mbat_pkg::ADDR_RAM_BANK_SEL,
                                                          ram_bank[7:0], 1'b0);
                        o_plan.res[1] = mbat_pkg::f_write(mbat_pkg::ADDR_RAM_ENABLE,
                                                          mbat_pkg::RAM_ENABLE_KEY, 1'b0);
                        o_plan.res[2] = mbat_pkg::f_run(ram_run_addr, c, 1'b0, 1'b0);
                        o_plan.res[3] = mbat_pkg::f_write(mbat_pkg::ADDR_RAM_ENABLE,
                                                          mbat_pkg::RAM_DISABLE_KEY, 1'b1);
                        o_plan.last_idx = 2'd3;
                    end
                end
                default: begin
                    o_plan.res[0] = mbat_pkg::f_reject();
                end
            endcase
        end
    end

endmodule

[sv/mbat_queue.sv]
// ----------------------------------------------------------------------------
// mbat_queue
// Two-entry plan queue decoupling the classifier from the result sequencer.
// ----------------------------------------------------------------------------
module mbat_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mbat_pkg::t_plan i_plan,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_empty,
    output mbat_pkg::t_plan o_head
);

    mbat_pkg::t_plan r_mem [2];
    logic            r_wr_ptr, n_wr_ptr;
    logic            r_rd_ptr, n_rd_ptr;
    logic [1:0]      r_count, n_count;

    assign o_ready = (r_count != 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_plan;
        end
    end

endmodule

[sv/mbat_back.sv]
// ----------------------------------------------------------------------------
// mbat_back
// Steps through the head plan and drives one result beat per cycle while the sink is ready.
// ----------------------------------------------------------------------------
module mbat_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  mbat_pkg::t_plan i_head,
    output logic            o_pop,
    mbat_rsp_if.source      o_rsp
);

    logic              r_valid, n_valid;
    logic [1:0]        r_idx, n_idx;
    mbat_pkg::t_result r_res;
    logic              load;

    assign load  = !i_empty && (!r_valid || o_rsp.ready);
    assign o_pop = load && (r_idx == i_head.last_idx);

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = o_pop ? 2'd0 : r_idx + 2'd1;
        end else if (o_rsp.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= i_head.res[r_idx];
        end
    end

    assign o_rsp.valid            = r_valid;
    assign o_rsp.kind             = r_res.kind;
    assign o_rsp.bus_address      = r_res.bus_address;
    assign o_rsp.write_value      = r_res.write_value;
    assign o_rsp.run_length       = r_res.run_length;
    assign o_rsp.fill_high_nibble = r_res.fill_high_nibble;
    assign o_rsp.last             = r_res.last;

endmodule

[test/mbc_bank_access_translator_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mbc_bank_access_translator_unit_tb
// Self-checking bench for the cartridge bank access translator. A short table
// of hand-picked requests is followed by random requests over a series of
// cartridge types. Each accepted request is translated by an independent
// predictor unless its row pins the expected beat, and each result beat is
// checked against the oldest expected beat, with random stalls on both channels.
// ----------------------------------------------------------------------------
module mbc_bank_access_translator_unit_tb;
    import mbat_pkg::*;

    localparam logic CMD_ROM = 1'b0;
    localparam logic CMD_RAM = 1'b1;

    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned RANDOM_PHASES = 12;
    localparam int unsigned PHASE_ITEMS   = 38;
    localparam int unsigned N_DIRECTED    = 25;

    localparam t_result REJECTED = '{KIND_REJECT, 16'h0000, 8'h00, 15'd0, 1'b0, 1'b1};
    localparam t_result NO_PIN   = '0;

    typedef struct packed {
        logic [7:0]  cart;
        logic        cmd;
        logic [22:0] addr;
        logic [14:0] cnt;
        logic        pinned;
        t_result     want;
    } t_stim_row;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    mbat_req_if req_ch ();
    mbat_rsp_if rsp_ch ();

    mbc_bank_access_translator_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    logic [7:0]  cart_now;
    t_result     pending_beats[$];
    logic        pin_en;
    t_result     pin_beat;
    bit          bursty;
    int unsigned rdy_hold;
    int unsigned quiet_cycles;
    int unsigned n_items, n_beats, n_errors, n_rejects, n_fills, n_carts;

    t_stim_row directed_rows [0:N_DIRECTED-1] = '{
        // no mapper, type byte still at its reset value
        '{8'h00, CMD_ROM, 23'h000000, 15'd1,      1'b1,
          '{KIND_RUN, 16'h0000, 8'h00, 15'd1, 1'b0, 1'b1}},
        '{8'h00, CMD_ROM, 23'h007FFF, 15'd1,      1'b1,
          '{KIND_RUN, 16'h7FFF, 8'h00, 15'd1, 1'b0, 1'b1}},
        '{8'h00, CMD_ROM, 23'h007FFF, 15'd2,      1'b1, REJECTED},
        '{8'h00, CMD_RAM, 23'h000000, 15'h2000,   1'b1,
          '{KIND_RUN, 16'hA000, 8'h00, 15'h2000, 1'b0, 1'b1}},
        '{8'h00, CMD_ROM, 23'h000000, 15'd0,      1'b1, REJECTED},
        '{8'h00, CMD_RAM, 23'h7FFFFF, 15'h7FFF,   1'b1, REJECTED},
        // mbc1
        '{8'h01, CMD_ROM, 23'h003FFF, 15'd1,      1'b1,
          '{KIND_RUN, 16'h3FFF, 8'h00, 15'd1, 1'b0, 1'b1}},
        '{8'h01, CMD_ROM, 23'h004000, 15'h4000,   1'b0, NO_PIN},
        '{8'h01, CMD_ROM, 23'h07FFFF, 15'd1,      1'b0, NO_PIN},
        '{8'h01, CMD_ROM, 23'h080000, 15'd1,      1'b1, REJECTED},
        '{8'h01, CMD_RAM, 23'h001FFF, 15'd1,      1'b0, NO_PIN},
        '{8'h01, CMD_ROM, 23'h003FFF, 15'd2,      1'b1, REJECTED},
        // mbc2
        '{8'h06, CMD_ROM, 23'h03C000, 15'd16,     1'b0, NO_PIN},
        '{8'h06, CMD_ROM, 23'h040000, 15'd1,      1'b1, REJECTED},
        '{8'h06, CMD_RAM, 23'h0001FF, 15'd1,      1'b0, NO_PIN},
        '{8'h06, CMD_RAM, 23'h0001FF, 15'd2,      1'b1, REJECTED},
        // mbc3
        '{8'h13, CMD_ROM, 23'h3FFFFF, 15'd1,      1'b0, NO_PIN},
        '{8'h13, CMD_ROM, 23'h400000, 15'd1,      1'b1, REJECTED},
        '{8'h13, CMD_RAM, 23'h00E000, 15'h2000,   1'b0, NO_PIN},
        '{8'h13, CMD_RAM, 23'h010000, 15'd1,      1'b1, REJECTED},
        // mbc5
        '{8'h19, CMD_ROM, 23'h7FFFFF, 15'd1,      1'b0, NO_PIN},
        '{8'h19, CMD_RAM, 23'h01E000, 15'd5,      1'b0, NO_PIN},
        '{8'h19, CMD_RAM, 23'h020000, 15'd1,      1'b1, REJECTED},
        // mbc7
        '{8'h22, CMD_RAM, 23'h000000, 15'd1,      1'b1, REJECTED},
        '{8'h22, CMD_ROM, 23'h004000, 15'h7FFF,   1'b1, REJECTED}
    };

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic t_mapper decode_mapper(logic [7:0] cart);
        if (cart >= 8'h01 && cart <= 8'h03) return MAP_MBC1;
        if (cart == 8'h05 || cart == 8'h06) return MAP_MBC2;
        if (cart >= 8'h0F && cart <= 8'h13) return MAP_MBC3;
        if (cart >= 8'h19 && cart <= 8'h1E) return MAP_MBC5;
        if (cart == 8'h22) return MAP_MBC7;
        return MAP_NONE;
    endfunction

    function automatic t_result beat(t_kind k, int unsigned a, int unsigned v,
                                     int unsigned len, logic fill, logic lst);
        t_result r;
        r.kind             = k;
        r.bus_address      = a[15:0];
        r.write_value      = v[7:0];
        r.run_length       = len[14:0];
        r.fill_high_nibble = fill;
        r.last             = lst;
        return r;
    endfunction

    // bus beats that one request turns into, appended to the outstanding list
    function automatic void translate_request(logic [7:0] cart, logic cmd,
                                              logic [22:0] addr, logic [14:0] cnt);
        t_mapper     m;
        int unsigned a, n, bank, off, lim;
        m = decode_mapper(cart);
        a = addr;
        n = cnt;
        if (n == 0) begin
            pending_beats.push_back(REJECTED);
            return;
        end
        if (cmd == CMD_ROM) begin
            if (m == MAP_NONE || a < ROM_FIXED_END) begin
                lim = (m == MAP_NONE) ? ROM_PLAIN_END : ROM_FIXED_END;
                if (a + n > lim) pending_beats.push_back(REJECTED);
                else pending_beats.push_back(beat(KIND_RUN, a, 0, n, 1'b0, 1'b1));
                return;
            end
            bank = a >> 14;
            off  = a & (ROM_BANK_SIZE - 1);
            case (m)
                MAP_MBC1: lim = 31;
                MAP_MBC2: lim = 15;
                MAP_MBC5: lim = 511;
                default:  lim = 255;
            endcase
            if (off + n > ROM_BANK_SIZE || bank > lim) begin
                pending_beats.push_back(REJECTED);
                return;
            end
            if (m == MAP_MBC5) begin
                pending_beats.push_back(beat(KIND_WRITE, ADDR_ROM_BANK_SEL, bank & 'hFF, 0,
                                             1'b0, 1'b0));
                pending_beats.push_back(beat(KIND_WRITE, ADDR_MBC5_ROM_HI, bank >> 8, 0,
                                             1'b0, 1'b0));
            end else begin
                pending_beats.push_back(beat(KIND_WRITE,
                    (m == MAP_MBC2) ? ADDR_MBC2_ROM_SEL : ADDR_ROM_BANK_SEL, bank, 0,
                    1'b0, 1'b0));
            end
            pending_beats.push_back(beat(KIND_RUN, ROM_BANK_SIZE + off, 0, n, 1'b0, 1'b1));
            return;
        end
        // cartridge ram
        if (m == MAP_NONE) begin
            if (a + n > RAM_BANK_END) pending_beats.push_back(REJECTED);
            else pending_beats.push_back(beat(KIND_RUN, RAM_WINDOW_BASE + a, 0, n,
                                              1'b0, 1'b1));
            return;
        end
        if (m == MAP_MBC7) begin
            pending_beats.push_back(REJECTED);
            return;
        end
        if (m == MAP_MBC2) begin
            if (a + n > MBC2_RAM_END) begin
                pending_beats.push_back(REJECTED);
                return;
            end
            pending_beats.push_back(beat(KIND_WRITE, ADDR_RAM_ENABLE, RAM_ENABLE_KEY, 0,
                                         1'b0, 1'b0));
            pending_beats.push_back(beat(KIND_RUN, RAM_WINDOW_BASE + a, 0, n, 1'b1, 1'b0));
            pending_beats.push_back(beat(KIND_WRITE, ADDR_RAM_ENABLE, RAM_DISABLE_KEY, 0,
                                         1'b0, 1'b1));
            return;
        end
        off = a & (RAM_BANK_SIZE - 1);
        if (m == MAP_MBC1) begin
            if (a + n > RAM_BANK_END) begin
                pending_beats.push_back(REJECTED);
                return;
            end
        end else begin
            bank = a >> 13;
            lim  = (m == MAP_MBC3) ? 7 : 15;
            if (bank > lim || off + n > RAM_BANK_SIZE) begin
                pending_beats.push_back(REJECTED);
                return;
            end
            pending_beats.push_back(beat(KIND_WRITE, ADDR_RAM_BANK_SEL, bank, 0,
                                         1'b0, 1'b0));
        end
        pending_beats.push_back(beat(KIND_WRITE, ADDR_RAM_ENABLE, RAM_ENABLE_KEY, 0,
                                     1'b0, 1'b0));
        pending_beats.push_back(beat(KIND_RUN, RAM_WINDOW_BASE + off, 0, n, 1'b0, 1'b0));
        pending_beats.push_back(beat(KIND_WRITE, ADDR_RAM_ENABLE, RAM_DISABLE_KEY, 0,
                                     1'b0, 1'b1));
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // result sink with random stall bursts
    always @(negedge clk) begin
        if (!bursty) begin
            rsp_ch.ready = 1'b1;
        end else if (rdy_hold != 0) begin
            rsp_ch.ready = 1'b0;
            rdy_hold--;
        end else if ($urandom_range(0, 5) == 0) begin
            rsp_ch.ready = 1'b0;
            rdy_hold = $urandom_range(0, 4);
        end else begin
            rsp_ch.ready = 1'b1;
        end
    end

    // request acceptance, result checking and watchdog
    always @(posedge clk) begin
        t_result want;
        bit      moved;
        if (rst_n) begin
            moved = 1'b0;
            if (req_ch.valid && req_ch.ready) begin
                moved = 1'b1;
                n_items++;
                if (pin_en) pending_beats.push_back(pin_beat);
                else translate_request(cart_now, req_ch.command, req_ch.cart_address,
                                       req_ch.byte_count);
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                moved = 1'b1;
                n_beats++;
                if (rsp_ch.kind == KIND_REJECT) n_rejects++;
                if (rsp_ch.fill_high_nibble) n_fills++;
                if (pending_beats.size() == 0) begin
                    $display("%0t: result beat with nothing outstanding, expected none, got kind %0d addr 0x%0h",
                             $time, rsp_ch.kind, rsp_ch.bus_address);
                    n_errors++;
                end else begin
                    want = pending_beats.pop_front();
                    check_field("kind", want.kind, rsp_ch.kind);
                    check_field("bus_address", want.bus_address, rsp_ch.bus_address);
                    check_field("write_value", want.write_value, rsp_ch.write_value);
                    check_field("run_length", want.run_length, rsp_ch.run_length);
                    check_field("fill_high_nibble", want.fill_high_nibble,
                                rsp_ch.fill_high_nibble);
                    check_field("last", want.last, rsp_ch.last);
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles, %0d beats outstanding",
                         $time, quiet_cycles, pending_beats.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_request(logic cmd, logic [22:0] addr, logic [14:0] cnt,
                                logic pinned, t_result want);
        int unsigned gap;
        gap = (bursty && $urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0;
        @(negedge clk);
        if (gap != 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid        = 1'b1;
        req_ch.command      = cmd;
        req_ch.cart_address = addr;
        req_ch.byte_count   = cnt;
        pin_en              = pinned;
        pin_beat            = want;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (pending_beats.size() != 0) @(negedge clk);
    endtask

    task automatic set_cart(logic [7:0] value);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_wdata = value;
        cart_now  = value;
        n_carts++;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // mostly well-formed requests for the current mapper, some pushed past a
    // window or bank limit, some pure noise
    task automatic make_request(output logic cmd, output logic [22:0] addr,
                                output logic [14:0] cnt);
        t_mapper     m;
        int unsigned sel, n, a, top, win;
        m   = decode_mapper(cart_now);
        sel = $urandom_range(0, 9);
        cmd = 1'($urandom_range(0, 1));
        if (sel == 9) begin
            addr = 23'($urandom);
            cnt  = 15'($urandom);
            return;
        end
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16384) : $urandom_range(1, 64);
        if (cmd == CMD_ROM) begin
            if (m == MAP_NONE) begin
                a = $urandom_range(0, 'h8000 - n);
            end else if ($urandom_range(0, 3) == 0) begin
                a = $urandom_range(0, 'h4000 - n);
            end else begin
                case (m)
                    MAP_MBC1: top = 31;
                    MAP_MBC2: top = 15;
                    MAP_MBC5: top = 511;
                    default:  top = 255;
                endcase
                a = ($urandom_range(1, top) << 14) | $urandom_range(0, 'h4000 - n);
            end
        end else begin
            win = (m == MAP_MBC2) ? 'h200 : 'h2000;
            n   = (n - 1) % win + 1;
            case (m)
                MAP_MBC3: top = 7;
                MAP_MBC5: top = 15;
                MAP_MBC7: top = 1023;
                default:  top = 0;
            endcase
            a = ($urandom_range(0, top) << 13) | $urandom_range(0, win - n);
        end
        if (sel == 7) n = n + $urandom_range(1, 64);
        if (sel == 8) a = a | ($urandom_range(1, 3) << 21);
        addr = a[22:0];
        cnt  = n[14:0];
    endtask

    initial begin
        logic [22:0] addr;
        logic [14:0] cnt;
        logic        cmd;
        logic [7:0]  cart;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = 8'h00;
        req_ch.valid        = 1'b0;
        req_ch.command      = CMD_ROM;
        req_ch.cart_address = '0;
        req_ch.byte_count   = '0;
        pin_en              = 1'b0;
        pin_beat            = NO_PIN;
        bursty              = 1'b1;
        rdy_hold            = 0;
        quiet_cycles        = 0;
        cart_now            = 8'h00;
        n_items = 0; n_beats = 0; n_errors = 0; n_rejects = 0; n_fills = 0; n_carts = 1;

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].cart != cart_now) set_cart(directed_rows[i].cart);
            send_request(directed_rows[i].cmd, directed_rows[i].addr, directed_rows[i].cnt,
                         directed_rows[i].pinned, directed_rows[i].want);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:  cart = 8'h00;
                1:  cart = 8'h02;
                2:  cart = 8'h05;
                3:  cart = 8'h0F;
                4:  cart = 8'h11;
                5:  cart = 8'h1E;
                6:  cart = 8'h22;
                7:  cart = 8'hFF;
                8:  cart = 8'h1B;
                9:  cart = 8'($urandom);
                10: cart = 8'h03;
                default: cart = 8'($urandom_range(0, 255));
            endcase
            set_cart(cart);
            bursty = (p == RANDOM_PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // hold the sender back until the output has fully drained
                if (p == 4 && k == PHASE_ITEMS / 2) wait_drained();
                make_request(cmd, addr, cnt);
                send_request(cmd, addr, cnt, 1'b0, NO_PIN);
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);

        $display("covered %0d requests giving %0d result beats across %0d cartridge type settings",
                 n_items, n_beats, n_carts);
        $display("  %0d rejected requests, %0d mbc2 ram runs with nibble fill, %0d mismatches",
                 n_rejects, n_fills, n_errors);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
